>>> design/pad_input_rle_text_decoder_macros.svh
// Assertion shorthands used by the file that checks this block.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef PAD_INPUT_RLE_TEXT_DECODER_MACROS_SVH
`define PAD_INPUT_RLE_TEXT_DECODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIRTD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIRTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pirtd_pkg.sv
package pirtd_pkg;

  localparam int RUN_BITS_DEF = 16;
  localparam int RUN_LEN_W    = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = 32;

  // Characters with a meaning in the text format.
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_A     = 8'h61;

  typedef enum logic [1:0] {PH_IDLE, PH_DIGITS, PH_COMMA, PH_LETTERS} phase_t;
  typedef enum logic [1:0] {SIGN_ABS, SIGN_PLUS, SIGN_MINUS} sign_t;
  typedef enum logic [1:0] {ERR_NONE, ERR_BAD_CHAR, ERR_NO_STREAM} err_t;
  typedef enum logic       {KIND_RUN, KIND_ERROR} kind_t;
  typedef enum logic [1:0] {STREAM_NONE, STREAM_P1, STREAM_P2} stream_t;

  typedef struct packed {
    kind_t                  kind;
    stream_t                player;
    logic [7:0]             pad_value;
    logic [RUN_LEN_W-1:0]   run_length;
    err_t                   error_code;
  } result_t;

  // All results caused by one character: one or two.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] letter_bit(input logic [7:0] c);
    logic [7:0] b;
    unique case (c)
      CH_R:    b = 8'(1) << 7;
      CH_L:    b = 8'(1) << 6;
      CH_D:    b = 8'(1) << 5;
      CH_U:    b = 8'(1) << 4;
      CH_T:    b = 8'(1) << 3;
      CH_C:    b = 8'(1) << 2;
      CH_B:    b = 8'(1) << 1;
      CH_A:    b = 8'(1) << 0;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] apply_sign(input sign_t s, input logic [7:0] prev,
                                            input logic [7:0] mask);
    logic [7:0] v;
    unique case (s)
      SIGN_PLUS:  v = prev | mask;
      SIGN_MINUS: v = prev & ~mask;
      default:    v = mask;
    endcase
    return v;
  endfunction

endpackage

>>> design/pirtd_parser.sv
module pirtd_parser import pirtd_pkg::*; #(
  parameter int RUN_BITS = RUN_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_byte,
  input  logic       end_of_text,
  output logic       push,
  output bundle_t    push_data
);

  localparam int NW = RUN_BITS + 4;

  phase_t              phase_r, phase_nxt;
  logic [RUN_BITS-1:0] rc_r, rc_nxt;
  logic [7:0]          mask_r, mask_nxt;
  sign_t               sign_r, sign_nxt;
  logic [7:0]          prev_r, prev_nxt;
  stream_t             stream_r, stream_nxt;
  logic                halted_r, halted_nxt;

  // State after the character itself, before the end-of-text flush.
  phase_t              ph_mid;
  logic [RUN_BITS-1:0] rc_mid;
  logic [7:0]          mask_mid;
  sign_t               sign_mid;
  logic [7:0]          prev_mid;
  stream_t             stream_mid;
  logic                halt_mid;

  logic                em1, err1, bad, em2, err2;
  logic [7:0]          v1, v2;

  logic                is_digit, is_ws, is_letter;
  logic [7:0]          lbit;
  logic [NW-1:0]       rc_ext, acc;
  logic [RUN_BITS-1:0] rc_acc;

  assign is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_ws     = (char_byte == CH_SPACE) || (char_byte == CH_LF) ||
                     (char_byte == CH_CR) || (char_byte == CH_TAB);
  assign lbit      = letter_bit(char_byte);
  assign is_letter = |lbit;

  // count * 10 + digit, saturating at all ones.
  assign rc_ext = NW'(rc_r);
  assign acc    = (rc_ext << 3) + (rc_ext << 1) + NW'(char_byte[3:0]);
  assign rc_acc = (|acc[NW-1:RUN_BITS]) ? '1 : acc[RUN_BITS-1:0];

  assign v1   = apply_sign(sign_r, prev_r, mask_r);
  assign err1 = em1 && (stream_r == STREAM_NONE);

  always_comb begin
    logic value_path;
    logic restart;
    logic start;
    value_path = 1'b0;
    restart    = 1'b0;
    start      = 1'b0;
    em1        = 1'b0;
    bad        = 1'b0;
    ph_mid     = phase_r;
    rc_mid     = rc_r;
    mask_mid   = mask_r;
    sign_mid   = sign_r;
    prev_mid   = prev_r;
    stream_mid = stream_r;
    halt_mid   = halted_r;
    if (!halted_r) begin
      unique case (phase_r)
        PH_IDLE:    start = 1'b1;
        PH_DIGITS: begin
          if (is_digit) rc_mid = rc_acc;
          else value_path = 1'b1;
        end
        PH_COMMA:   value_path = 1'b1;
        PH_LETTERS: begin
          if (is_letter) begin
            mask_mid = mask_r | lbit;
          end else begin
            em1     = 1'b1;
            restart = 1'b1;
          end
        end
        default: ;
      endcase

      if (value_path) begin
        if (char_byte == CH_UNDER) begin
          em1 = 1'b1;
        end else if (char_byte == CH_PLUS) begin
          sign_mid = SIGN_PLUS;
          ph_mid   = PH_LETTERS;
        end else if (char_byte == CH_MINUS) begin
          sign_mid = SIGN_MINUS;
          ph_mid   = PH_LETTERS;
        end else if (is_letter) begin
          mask_mid = mask_r | lbit;
          ph_mid   = PH_LETTERS;
        end else begin
          em1     = 1'b1;
          restart = 1'b1;
        end
      end

      if (em1) begin
        if (stream_r == STREAM_NONE) halt_mid = 1'b1;
        else prev_mid = v1;
        ph_mid   = PH_IDLE;
        rc_mid   = '0;
        mask_mid = '0;
        sign_mid = SIGN_ABS;
        start    = restart && (stream_r != STREAM_NONE);
      end

      if (start) begin
        if (char_byte == CH_BANG) begin
          stream_mid = STREAM_P1;
          prev_mid   = '0;
        end else if (char_byte == CH_AT) begin
          stream_mid = STREAM_P2;
          prev_mid   = '0;
        end else if (is_digit) begin
          rc_mid = RUN_BITS'(char_byte[3:0]);
          ph_mid = PH_DIGITS;
        end else if (char_byte == CH_COMMA) begin
          rc_mid = RUN_BITS'(1);
          ph_mid = PH_COMMA;
        end else if (!is_ws) begin
          bad      = 1'b1;
          halt_mid = 1'b1;
        end
      end
    end
  end

  // End of text flushes a pending run and starts a fresh text.
  assign em2  = end_of_text && !halt_mid && (ph_mid != PH_IDLE);
  assign err2 = em2 && (stream_mid == STREAM_NONE);
  assign v2   = apply_sign(sign_mid, prev_mid, mask_mid);

  always_comb begin
    phase_nxt  = ph_mid;
    rc_nxt     = rc_mid;
    mask_nxt   = mask_mid;
    sign_nxt   = sign_mid;
    prev_nxt   = prev_mid;
    stream_nxt = stream_mid;
    halted_nxt = halt_mid;
    if (em2) begin
      if (err2) halted_nxt = 1'b1;
      else prev_nxt = v2;
      phase_nxt = PH_IDLE;
      rc_nxt    = '0;
      mask_nxt  = '0;
      sign_nxt  = SIGN_ABS;
    end
    if (end_of_text && !halted_nxt) begin
      phase_nxt  = PH_IDLE;
      rc_nxt     = '0;
      mask_nxt   = '0;
      sign_nxt   = SIGN_ABS;
      prev_nxt   = '0;
      stream_nxt = STREAM_NONE;
    end
  end

  always_comb begin
    result_t r_em1;
    result_t r_bad;
    result_t r_em2;
    result_t r_err;
    r_err = '{kind: KIND_ERROR, player: STREAM_NONE, pad_value: '0,
              run_length: '0, error_code: ERR_NO_STREAM};
    r_em1 = '{kind: KIND_RUN, player: stream_r, pad_value: v1,
              run_length: RUN_LEN_W'(rc_r), error_code: ERR_NONE};
    if (err1) r_em1 = r_err;
    r_em2 = '{kind: KIND_RUN, player: stream_mid, pad_value: v2,
              run_length: RUN_LEN_W'(rc_mid), error_code: ERR_NONE};
    if (err2) r_em2 = r_err;
    r_bad = r_err;
    r_bad.error_code = ERR_BAD_CHAR;

    push_data.first  = em1 ? r_em1 : (bad ? r_bad : r_em2);
    push_data.second = (em1 && bad) ? r_bad : r_em2;
    push_data.two    = (em1 && (bad || em2)) || (bad && em2);
  end

  assign push = accept && (em1 || bad || em2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      rc_r     <= '0;
      mask_r   <= '0;
      sign_r   <= SIGN_ABS;
      prev_r   <= '0;
      stream_r <= STREAM_NONE;
      halted_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      rc_r     <= rc_nxt;
      mask_r   <= mask_nxt;
      sign_r   <= sign_nxt;
      prev_r   <= prev_nxt;
      stream_r <= stream_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> design/pirtd_queue.sv
module pirtd_queue import pirtd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  bundle_t   push_data,
  input  logic      pop,
  output bundle_t   head,
  output q_status_t qs
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bundle_t         mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign qs.full  = (count_r == CW'(DEPTH));
  assign qs.empty = (count_r == '0);
  assign head     = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> design/pirtd_emitter.sv
module pirtd_emitter import pirtd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  bundle_t   head,
  input  q_status_t qs,
  output logic      pop,
  input  logic      out_ready,
  output logic      out_valid,
  output result_t   out_res,
  output logic      out_last
);

  logic    valid_r, valid_nxt;
  logic    sel_r, sel_nxt;
  result_t res_r;
  logic    last_r;
  logic    load, pick_last;
  result_t pick;

  // Output register is free when empty or being drained this cycle.
  assign load      = !qs.empty && (!valid_r || out_ready);
  assign pick      = sel_r ? head.second : head.first;
  assign pick_last = sel_r || !head.two;
  assign pop       = load && pick_last;

  always_comb begin
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    if (!valid_r || out_ready) valid_nxt = !qs.empty;
    if (load) sel_nxt = !pick_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r  <= pick;
      last_r <= pick_last;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;
  assign out_last  = last_r;

endmodule

>>> design/pad_input_rle_text_decoder.sv
// Channel | Side   | Beat contents
// in_*    | slave  | tdata[7:0] char_byte; tlast end_of_text
// out_*   | master | tdata player, pad_value, run_length, error_code; tuser kind;
//         |        | tlast last_result
//
// One character is accepted per cycle while the queue has room. Each character is
// parsed in the cycle it is accepted; its one or two results enter a small queue and
// leave through a registered output stage, one beat per cycle while the sink is ready,
// so a character with two results holds that stage for both of its beats.
// Reset is synchronous and active low; it clears the parser state and empties the queue.
// in_tready drops only while the queue is full; after an error the block keeps taking
// characters but gives no further beats until reset.
`include "pad_input_rle_text_decoder_macros.svh"

module pad_input_rle_text_decoder import pirtd_pkg::*; #(
  parameter int RUN_BITS    = RUN_BITS_DEF,
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] char_byte
  input  logic                   in_tlast,   // end_of_text
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] player, [9:2] pad_value, [25:10] run_length, [27:26] error_code,
  // [31:28] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,  // [0] kind
  output logic                   out_tlast   // last_result
);

  localparam int OUT_PAD_W = OUT_TDATA_W - $bits(result_t) + 1;

  logic      accept;
  logic      push;
  bundle_t   push_data;
  bundle_t   head;
  q_status_t qs;
  logic      pop;
  result_t   out_res;

  // The parser may take a character whenever its results have room in the queue.
  assign in_tready = !qs.full;
  assign accept    = in_tvalid && in_tready;

  pirtd_parser #(
    .RUN_BITS (RUN_BITS)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .char_byte   (in_tdata[7:0]),
    .end_of_text (in_tlast),
    .push        (push),
    .push_data   (push_data)
  );

  pirtd_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  pirtd_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .qs        (qs),
    .pop       (pop),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res),
    .out_last  (out_tlast)
  );

  // Kind travels on tuser; the remaining fields are packed lowest first.
  assign out_tuser = out_res.kind;
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_res.error_code, out_res.run_length,
                      out_res.pad_value, out_res.player};

  // An error beat carries only its code.
  `PIRTD_ASSERT_SAME(a_error_fields, out_tvalid && out_res.kind == KIND_ERROR, out_res.player == STREAM_NONE && out_res.pad_value == 8'd0 && out_res.run_length == '0 && out_res.error_code != ERR_NONE, "error beat carries run fields or no code")

  // A run beat names a stream and carries no error code.
  `PIRTD_ASSERT_SAME(a_run_fields, out_tvalid && out_res.kind == KIND_RUN, (out_res.player == STREAM_P1 || out_res.player == STREAM_P2) && out_res.error_code == ERR_NONE, "run beat without a stream or with an error code")

  // An error halts the parser, so it is always the final result of its character.
  `PIRTD_ASSERT_SAME(a_error_last, out_tvalid && out_res.kind == KIND_ERROR, out_tlast, "error beat not marked last")

  // Nothing follows an error until reset.
  `PIRTD_ASSERT_NEXT(a_quiet_after_error, out_tvalid && out_tready && out_res.kind == KIND_ERROR, !out_tvalid && qs.empty, "beat after an error")

endmodule

>>> test/rle_token_checker.sv
module rle_token_checker import pirtd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [7:0] char_byte
  input  logic                   in_tlast,    // end_of_text
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // [1:0] player, [9:2] pad_value, [25:10] run_length, [27:26] error_code, [31:28] zero
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,   // [0] kind
  input  logic                   out_tlast,   // last_result
  output int                     mismatch_count,
  output int                     open_beats,
  output int                     beats_checked
);

  localparam longint unsigned COUNT_CEILING = (64'd1 << RUN_BITS_DEF) - 64'd1;

  typedef struct {
    result_t beat;
    logic    last;
  } token_beat_t;

  // Decoder state as the text has left it so far.
  phase_t          phase = PH_IDLE;
  longint unsigned run_cnt = 0;
  logic [7:0]      mask = '0;
  sign_t           sign_sel = SIGN_ABS;
  logic [7:0]      prev_val = '0;
  stream_t         stream = STREAM_NONE;
  logic            locked = 1'b0;

  result_t     char_beats[$];
  token_beat_t token_q[$];
  int          misses = 0;
  int          compared = 0;

  function automatic logic [7:0] button_bit(input logic [7:0] c);
    case (c)
      CH_R:    return 8'h80;
      CH_L:    return 8'h40;
      CH_D:    return 8'h20;
      CH_U:    return 8'h10;
      CH_T:    return 8'h08;
      CH_C:    return 8'h04;
      CH_B:    return 8'h02;
      CH_A:    return 8'h01;
      default: return 8'h00;
    endcase
  endfunction

  function automatic void add_beat(input kind_t k, input stream_t p, input logic [7:0] v,
                                   input logic [RUN_LEN_W-1:0] n, input err_t e);
    result_t r;
    r.kind = k;
    r.player = p;
    r.pad_value = v;
    r.run_length = n;
    r.error_code = e;
    char_beats.insert(char_beats.size(), r);
  endfunction

  function automatic void clear_run();
    phase = PH_IDLE;
    run_cnt = 0;
    mask = '0;
    sign_sel = SIGN_ABS;
  endfunction

  function automatic void close_run();
    logic [7:0] v;
    case (sign_sel)
      SIGN_PLUS:  v = prev_val | mask;
      SIGN_MINUS: v = prev_val & ~mask;
      default:    v = mask;
    endcase
    if (stream == STREAM_NONE) begin
      add_beat(KIND_ERROR, STREAM_NONE, 8'h00, '0, ERR_NO_STREAM);
      locked = 1'b1;
    end else begin
      add_beat(KIND_RUN, stream, v, run_cnt[RUN_LEN_W-1:0], ERR_NONE);
      prev_val = v;
    end
    clear_run();
  endfunction

  function automatic void open_run(input logic [7:0] c);
    if (c == CH_BANG) begin
      stream = STREAM_P1;
      prev_val = '0;
    end else if (c == CH_AT) begin
      stream = STREAM_P2;
      prev_val = '0;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      run_cnt = 64'(c - CH_ZERO);
      phase = PH_DIGITS;
    end else if (c == CH_COMMA) begin
      run_cnt = 1;
      phase = PH_COMMA;
    end else if (!(c inside {CH_SPACE, CH_LF, CH_CR, CH_TAB})) begin
      add_beat(KIND_ERROR, STREAM_NONE, 8'h00, '0, ERR_BAD_CHAR);
      locked = 1'b1;
    end
  endfunction

  function automatic void close_and_reopen(input logic [7:0] c);
    close_run();
    if (!locked) open_run(c);
  endfunction

  // First character after a count: a value starts here, or the run ends with value zero.
  function automatic void begin_value(input logic [7:0] c);
    logic [7:0] b;
    b = button_bit(c);
    if (c == CH_UNDER) begin
      mask = '0;
      sign_sel = SIGN_ABS;
      close_run();
    end else if (c == CH_PLUS) begin
      sign_sel = SIGN_PLUS;
      phase = PH_LETTERS;
    end else if (c == CH_MINUS) begin
      sign_sel = SIGN_MINUS;
      phase = PH_LETTERS;
    end else if (b != 8'h00) begin
      mask |= b;
      phase = PH_LETTERS;
    end else begin
      close_and_reopen(c);
    end
  endfunction

  function automatic void decode_char(input logic [7:0] c, input logic eot);
    longint unsigned grown;
    token_beat_t     tb;
    char_beats.delete();
    if (locked) return;
    case (phase)
      PH_IDLE: open_run(c);
      PH_DIGITS: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          grown = run_cnt * 10 + 64'(c - CH_ZERO);
          run_cnt = (grown > COUNT_CEILING) ? COUNT_CEILING : grown;
        end else begin
          begin_value(c);
        end
      end
      PH_COMMA: begin_value(c);
      default: begin
        if (button_bit(c) != 8'h00) mask |= button_bit(c);
        else close_and_reopen(c);
      end
    endcase
    if (eot && !locked) begin
      if (phase != PH_IDLE) close_run();
      if (!locked) begin
        clear_run();
        prev_val = '0;
        stream = STREAM_NONE;
      end
    end
    foreach (char_beats[i]) begin
      tb.beat = char_beats[i];
      tb.last = (i == char_beats.size() - 1);
      token_q.insert(token_q.size(), tb);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      misses++;
    end
  endfunction

  always @(posedge clk) begin
    token_beat_t want;
    if (!rst_n) begin
      locked = 1'b0;
      clear_run();
      prev_val = '0;
      stream = STREAM_NONE;
      token_q.delete();
    end else begin
      if (in_tvalid && in_tready) decode_char(in_tdata[7:0], in_tlast);
      if (out_tvalid && out_tready) begin
        compared++;
        if (token_q.size() == 0) begin
          $error("result beat with nothing pending: tdata=%h tuser=%b tlast=%b",
                 out_tdata, out_tuser, out_tlast);
          misses++;
        end else begin
          want = token_q.pop_front();
          check_field("kind", 32'(want.beat.kind), 32'(out_tuser));
          check_field("player", 32'(want.beat.player), 32'(out_tdata[1:0]));
          check_field("pad_value", 32'(want.beat.pad_value), 32'(out_tdata[9:2]));
          check_field("run_length", 32'(want.beat.run_length), 32'(out_tdata[25:10]));
          check_field("error_code", 32'(want.beat.error_code), 32'(out_tdata[27:26]));
          check_field("tdata padding", 32'd0, 32'(out_tdata[31:28]));
          check_field("last_result", 32'(want.last), 32'(out_tlast));
        end
      end
    end
    mismatch_count <= misses;
    open_beats <= token_q.size();
    beats_checked <= compared;
  end

endmodule

>>> test/testbench.sv
// Top of the decoder test. It only produces character beats and sink backpressure
// and gives the verdict; rle_token_checker predicts and compares every result beat.
module testbench;
  import pirtd_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;

  // One character of the text together with its end-of-text flag.
  typedef struct packed {
    logic       eot;
    logic [7:0] ch;
  } text_char_t;

  // The way the run is brought to its halting error. Only one of them can be
  // taken per run, since the block stays halted until the next reset.
  typedef enum {
    CLOSE_BAD_BYTE,
    CLOSE_NUL,
    CLOSE_LETTER_AFTER_ZERO,
    CLOSE_NO_STREAM
  } closing_error_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;     // [7:0] char_byte
  logic                   in_tlast = 1'b0;   // end_of_text
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [1:0] player, [9:2] pad_value, [25:10] run_length, [27:26] error_code, [31:28] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;         // [0] kind
  logic                   out_tlast;         // last_result

  int mismatch_count;
  int open_beats;
  int beats_checked;

  int sent = 0;
  int texts = 0;
  logic calm;
  text_char_t text_q[$];

  logic [7:0] pad_letters[8] = '{CH_R, CH_L, CH_D, CH_U, CH_T, CH_C, CH_B, CH_A};
  logic [7:0] blanks[4] = '{CH_SPACE, CH_LF, CH_CR, CH_TAB};

  pad_input_rle_text_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  rle_token_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tlast       (in_tlast),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .open_beats     (open_beats),
    .beats_checked  (beats_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A window of characters in the middle of the random part runs with neither
  // side pausing, so the decoder also sees back-to-back beats at full rate.
  assign calm = (sent >= 500 && sent < 700);

  // Outside the calm window the sink pauses at random, with a chance of about 13 percent.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 13);
  end

  function automatic void queue_char(input logic [7:0] c, input logic eot);
    text_char_t tc;
    tc.eot = eot;
    tc.ch  = c;
    text_q.insert(text_q.size(), tc);
  endfunction

  function automatic void queue_string(input string s);
    for (int i = 0; i < s.len(); i++) queue_char(s[i], 1'b0);
  endfunction

  // A run count: either a comma or a string of digits. Now and then the digit
  // string is long enough to push the count into saturation.
  function automatic void compose_count();
    int digits;
    if ($urandom_range(9) < 3) begin
      queue_char(CH_COMMA, 1'b0);
    end else begin
      digits = ($urandom_range(14) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
      repeat (digits) queue_char(CH_ZERO + 8'($urandom_range(9)), 1'b0);
    end
  endfunction

  // A value: '_', nothing at all, or an optional sign followed by button letters.
  function automatic void compose_value();
    int pick;
    int letters;
    pick = $urandom_range(19);
    if (pick < 3) begin
      queue_char(CH_UNDER, 1'b0);
    end else if (pick > 3) begin
      case ($urandom_range(2))
        1: queue_char(CH_PLUS, 1'b0);
        2: queue_char(CH_MINUS, 1'b0);
        default: ;
      endcase
      letters = $urandom_range(8);
      repeat (letters) queue_char(pad_letters[$urandom_range(7)], 1'b0);
    end
  endfunction

  // A well-formed text: a stream selection, then runs with the odd stream switch
  // and some whitespace between them. The last run may still be open when the text
  // ends, which exercises the flush at end of text.
  function automatic void compose_text();
    int runs;
    text_q.delete();
    queue_char(($urandom_range(1) != 0) ? CH_AT : CH_BANG, 1'b0);
    runs = $urandom_range(1, 12);
    repeat (runs) begin
      if ($urandom_range(9) == 0) queue_char(($urandom_range(1) != 0) ? CH_AT : CH_BANG, 1'b0);
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 2)) queue_char(blanks[$urandom_range(3)], 1'b0);
      compose_count();
      compose_value();
    end
    if ($urandom_range(5) == 0) queue_char(blanks[$urandom_range(3)], 1'b0);
    text_q[text_q.size() - 1].eot = 1'b1;
  endfunction

  // Presents one character and holds it until the decoder takes the beat.
  task automatic send_char(input text_char_t tc);
    while (!calm && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tc.ch;
    in_tlast  <= tc.eot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i]);
    texts++;
  endtask

  initial begin
    closing_error_t closing;
    logic [7:0] stray;
    int waited;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed text: a zero run, every button letter, a saturating count, both
    // streams, plus and minus values, a tab, a space and a newline between tokens and
    // a bare comma count flushed by the end of text.
    text_q.delete();
    queue_string("!0_,rldutcba\t@99999+r 2-r\n,");
    text_q[text_q.size() - 1].eot = 1'b1;
    send_text();

    while (sent < 1200) begin
      compose_text();
      send_text();
    end

    // Closing error. The previous text ended with its end-of-text beat, so no
    // stream is selected at this point.
    closing = closing_error_t'($urandom_range(3));
    text_q.delete();
    case (closing)
      CLOSE_BAD_BYTE: begin
        // A run in progress is closed and then the byte is rejected: two beats.
        queue_string("!5a");
        do begin
          stray = 8'($urandom_range(255));
        end while (stray inside {CH_BANG, CH_AT, CH_COMMA, [CH_ZERO:CH_NINE],
                                 CH_SPACE, CH_LF, CH_CR, CH_TAB,
                                 CH_R, CH_L, CH_D, CH_U, CH_T, CH_C, CH_B, CH_A});
        queue_char(stray, 1'b0);
      end
      CLOSE_NUL: begin
        queue_string("!,b");
        queue_char(CH_NUL, 1'b0);
      end
      CLOSE_LETTER_AFTER_ZERO: queue_string("!3_a");
      default: queue_string("12+a ");
    endcase

    // Once halted the decoder must stay silent, whatever arrives.
    queue_char(8'hFF, 1'b1);
    queue_char(8'h80, 1'b0);
    repeat (24) queue_char(8'($urandom_range(255)), 1'($urandom_range(1)));
    send_text();

    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (open_beats != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    if (open_beats != 0) $error("%0d expected result beats never arrived", open_beats);
    $display("Run covered %0d characters in %0d texts and compared %0d result beats,",
             sent, texts, beats_checked);
    $display("closing with the %s error case.", closing.name());
    if (mismatch_count == 0 && open_beats == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Safety net far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
